// ===== src/socks5_pkg.sv =====
// Package for the SOCKS5 client handshake block: protocol constants, phase
// codes and the transaction and result types shared by the sequencer and top level.
// No dependencies.
`default_nettype none

package socks5_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_NAME  = 2'd1;
  localparam logic [1:0] CMD_RECV  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Protocol bytes.
  localparam logic [7:0] PROTO_VER   = 8'h05;
  localparam logic [7:0] NMETHODS    = 8'h01;
  localparam logic [7:0] AUTH_NONE   = 8'h00;
  localparam logic [7:0] REQ_CONNECT = 8'h01;
  localparam logic [7:0] RSV_BYTE    = 8'h00;
  localparam logic [7:0] STATUS_OK   = 8'h00;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;

  // Bytes to skip after the address type: address plus two port bytes.
  localparam logic [8:0] SKIP_IPV4 = 9'd6;
  localparam logic [8:0] SKIP_IPV6 = 9'd18;
  localparam logic [8:0] PORT_LEN  = 9'd2;

  // Most results one input transaction can cause.
  localparam int MAX_RES = 5;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_GREET = 6'b000010,
    PH_NAME  = 6'b000100,
    PH_HEAD  = 6'b001000,
    PH_DLEN  = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [15:0] dest_port;
    logic [7:0]  name_length;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
  } result_t;

  typedef struct packed {
    logic [2:0]                 count;
    result_t [MAX_RES-1:0]      res;
  } bundle_t;

endpackage

`default_nettype wire

// ===== src/socks5_fsm.sv =====
// Handshake sequencer: holds the protocol phase, counters and stored request
// fields, and works out the results of one transaction. Depends on socks5_pkg.
`default_nettype none

module socks5_fsm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire socks5_pkg::item_t  item,
  output socks5_pkg::bundle_t     bundle
);
  import socks5_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] port_r, port_nxt;
  logic [8:0]  cnt_inc;
  logic        fail_c;
  bundle_t     bund_c;

  assign cnt_inc = cnt_r + 9'd1;

  // Next state and the result bundle for the transaction in the input register.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    port_nxt  = port_r;
    fail_c    = 1'b0;
    bund_c    = '0;
    case (phase_r)
      PH_IDLE: begin
        if (item.command != CMD_START || item.name_length == 8'd0) begin
          fail_c = 1'b1;
        end else begin
          len_nxt   = item.name_length;
          port_nxt  = item.dest_port;
          bund_c.count  = 3'd3;
          bund_c.res[0] = '{kind: KIND_TX, tx_byte: PROTO_VER};
          bund_c.res[1] = '{kind: KIND_TX, tx_byte: NMETHODS};
          bund_c.res[2] = '{kind: KIND_TX, tx_byte: AUTH_NONE};
          phase_nxt = PH_GREET;
          cnt_nxt   = 9'd0;
        end
      end
      PH_GREET: begin
        if (item.command != CMD_RECV) begin
          fail_c = 1'b1;
        end else if (cnt_r == 9'd0) begin
          if (item.data_byte != PROTO_VER) fail_c = 1'b1;
          else cnt_nxt = 9'd1;
        end else if (item.data_byte != AUTH_NONE) begin
          fail_c = 1'b1;
        end else begin
          bund_c.count  = 3'd5;
          bund_c.res[0] = '{kind: KIND_TX, tx_byte: PROTO_VER};
          bund_c.res[1] = '{kind: KIND_TX, tx_byte: REQ_CONNECT};
          bund_c.res[2] = '{kind: KIND_TX, tx_byte: RSV_BYTE};
          bund_c.res[3] = '{kind: KIND_TX, tx_byte: ATYP_DOMAIN};
          bund_c.res[4] = '{kind: KIND_TX, tx_byte: len_r};
          phase_nxt = PH_NAME;
          cnt_nxt   = 9'd0;
        end
      end
      PH_NAME: begin
        if (item.command != CMD_NAME) begin
          fail_c = 1'b1;
        end else begin
          bund_c.res[0] = '{kind: KIND_TX, tx_byte: item.data_byte};
          if (cnt_inc >= {1'b0, len_r}) begin
            // Last name byte: append the port, high byte first.
            bund_c.count  = 3'd3;
            bund_c.res[1] = '{kind: KIND_TX, tx_byte: port_r[15:8]};
            bund_c.res[2] = '{kind: KIND_TX, tx_byte: port_r[7:0]};
            phase_nxt = PH_HEAD;
            cnt_nxt   = 9'd0;
          end else begin
            bund_c.count = 3'd1;
            cnt_nxt      = cnt_inc;
          end
        end
      end
      PH_HEAD: begin
        if (item.command != CMD_RECV) begin
          fail_c = 1'b1;
        end else if (cnt_r == 9'd0) begin
          if (item.data_byte != PROTO_VER) fail_c = 1'b1;
          else cnt_nxt = cnt_inc;
        end else if (cnt_r == 9'd1) begin
          if (item.data_byte != STATUS_OK) fail_c = 1'b1;
          else cnt_nxt = cnt_inc;
        end else if (cnt_r >= 9'd3) begin
          // Address type decides how much of the bound address to skip.
          case (item.data_byte)
            ATYP_IPV4: begin
              phase_nxt = PH_SKIP;
              cnt_nxt   = SKIP_IPV4;
            end
            ATYP_IPV6: begin
              phase_nxt = PH_SKIP;
              cnt_nxt   = SKIP_IPV6;
            end
            ATYP_DOMAIN: begin
              phase_nxt = PH_DLEN;
              cnt_nxt   = 9'd0;
            end
            default: fail_c = 1'b1;
          endcase
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_DLEN: begin
        if (item.command != CMD_RECV) begin
          fail_c = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
          cnt_nxt   = {1'b0, item.data_byte} + PORT_LEN;
        end
      end
      PH_SKIP: begin
        if (item.command != CMD_RECV) begin
          fail_c = 1'b1;
        end else if (cnt_r > 9'd1) begin
          cnt_nxt = cnt_r - 9'd1;
        end else begin
          bund_c.count  = 3'd1;
          bund_c.res[0] = '{kind: KIND_OK, tx_byte: 8'h00};
          phase_nxt = PH_IDLE;
          cnt_nxt   = 9'd0;
        end
      end
      default: fail_c = 1'b1;
    endcase

    // Any failure gives a single failure result and a return to idle.
    if (fail_c) begin
      bund_c        = '0;
      bund_c.count  = 3'd1;
      bund_c.res[0] = '{kind: KIND_FAIL, tx_byte: 8'h00};
      phase_nxt     = PH_IDLE;
      cnt_nxt       = 9'd0;
      len_nxt       = len_r;
      port_nxt      = port_r;
    end
  end

  assign bundle = bund_c;

  // State registers move on when the transaction leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 9'd0;
      len_r   <= 8'd0;
      port_r  <= 16'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/socks5_client_handshake_top.sv =====
// Path: an accepted transaction waits in the input register until the result register
// drains, then moves into it; its results show one per cycle while out_stall is low.
// Throughput: one transaction per cycle for those causing at most one result, when the
// output does not stall; one with more results holds the next in the input register.
// Reset: synchronous, active low; the block returns to idle with no results pending.
// Top level of the SOCKS5 client handshake. Depends on socks5_pkg and socks5_fsm.
`default_nettype none

module socks5_client_handshake_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [7:0]  in_name_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);
  import socks5_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    bnd_valid_r, bnd_valid_nxt;
  bundle_t bnd_r;
  bundle_t step_bundle;
  logic [2:0] idx_r, idx_nxt;
  logic    in_fire, out_fire, drain_done, advance;
  result_t cur_res;

  // Handshake control: the input register moves on once the result register empties.
  assign out_valid  = bnd_valid_r;
  assign cur_res    = bnd_r.res[idx_r];
  assign out_kind   = cur_res.kind;
  assign out_tx_byte = cur_res.tx_byte;
  assign out_last   = (idx_r == (bnd_r.count - 3'd1));
  assign out_fire   = out_valid && !out_stall;
  assign drain_done = !bnd_valid_r || (out_fire && out_last);
  assign advance    = s1_valid_r && drain_done;
  assign in_stall   = s1_valid_r && !drain_done;
  assign in_fire    = in_valid && !in_stall;

  socks5_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item_r),
    .bundle  (step_bundle)
  );

  // Next values of the input and result registers.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    bnd_valid_nxt = bnd_valid_r;
    idx_nxt       = idx_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    if (advance) begin
      bnd_valid_nxt = (step_bundle.count != 3'd0);
      idx_nxt       = 3'd0;
    end else if (out_fire) begin
      if (out_last) bnd_valid_nxt = 1'b0;
      else idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      bnd_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      bnd_valid_r <= bnd_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{command: in_command, data_byte: in_data_byte,
                     dest_port: in_dest_port, name_length: in_name_length};
    end
    if (advance) bnd_r <= step_bundle;
  end

`ifndef SYNTH
  // The result index never runs past the stored result count.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (idx_r < bnd_r.count))
    else $error("result index beyond result count");

  // An accepted transaction never overwrites one still waiting in the input register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!s1_valid_r || advance))
    else $error("input register overwritten");

  // A result that is not the last one is always followed by another.
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last) |=> out_valid)
    else $error("results of a transaction lost");

  // Success and failure are always the final result of their transaction.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_TX) |-> out_last)
    else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_socks5_client_handshake_top.sv =====
// Self-checking testbench for the SOCKS5 client handshake block: a directed
// opening, then random handshakes under varying back-pressure on both channels.
// Depends on socks5_pkg and socks5_client_handshake_top.
`timescale 1ns / 1ps

module tb_socks5_client_handshake_top;
  import socks5_pkg::*;

  // Command code that no phase accepts.
  localparam logic [1:0] CMD_BAD = 2'd3;

  // One result beat as the output channel presents it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
  } out_beat_t;

  // Tracks the handshake state, predicts the bytes and verdicts of each
  // accepted transaction and checks the results as they arrive.
  class handshake_checker;
    phase_t      phase;
    logic [8:0]  byte_count;
    logic [7:0]  saved_len;
    logic [15:0] saved_port;
    out_beat_t   step_beats[$];
    out_beat_t   awaited[$];
    int          mismatches;
    int          results_seen;

    function new();
      phase = PH_IDLE;
      byte_count = '0;
      saved_len = '0;
      saved_port = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] b);
      step_beats.push_back('{kind: kind, tx_byte: b, last: 1'b0});
    endfunction

    // Advance the handshake by one accepted transaction and queue its results.
    function void note_item(item_t it);
      bit failed;
      failed = 1'b0;
      step_beats.delete();
      case (phase)
        PH_IDLE: begin
          if (it.command != CMD_START || it.name_length == 8'd0) begin
            failed = 1'b1;
          end else begin
            saved_len = it.name_length;
            saved_port = it.dest_port;
            emit(KIND_TX, PROTO_VER);
            emit(KIND_TX, NMETHODS);
            emit(KIND_TX, AUTH_NONE);
            phase = PH_GREET;
            byte_count = '0;
          end
        end
        PH_GREET: begin
          if (it.command != CMD_RECV) begin
            failed = 1'b1;
          end else if (byte_count == 9'd0) begin
            if (it.data_byte != PROTO_VER) failed = 1'b1;
            else byte_count = 9'd1;
          end else if (it.data_byte != AUTH_NONE) begin
            failed = 1'b1;
          end else begin
            emit(KIND_TX, PROTO_VER);
            emit(KIND_TX, REQ_CONNECT);
            emit(KIND_TX, RSV_BYTE);
            emit(KIND_TX, ATYP_DOMAIN);
            emit(KIND_TX, saved_len);
            phase = PH_NAME;
            byte_count = '0;
          end
        end
        PH_NAME: begin
          if (it.command != CMD_NAME) begin
            failed = 1'b1;
          end else begin
            emit(KIND_TX, it.data_byte);
            byte_count = byte_count + 9'd1;
            // After the last name byte the port follows, high byte first.
            if (byte_count >= {1'b0, saved_len}) begin
              emit(KIND_TX, saved_port[15:8]);
              emit(KIND_TX, saved_port[7:0]);
              phase = PH_HEAD;
              byte_count = '0;
            end
          end
        end
        PH_HEAD: begin
          if (it.command != CMD_RECV) begin
            failed = 1'b1;
          end else if (byte_count == 9'd0) begin
            if (it.data_byte != PROTO_VER) failed = 1'b1;
            else byte_count = 9'd1;
          end else if (byte_count == 9'd1) begin
            if (it.data_byte != STATUS_OK) failed = 1'b1;
            else byte_count = 9'd2;
          end else if (byte_count == 9'd2) begin
            // The reserved byte is not checked.
            byte_count = 9'd3;
          end else begin
            case (it.data_byte)
              ATYP_IPV4: begin
                phase = PH_SKIP;
                byte_count = SKIP_IPV4;
              end
              ATYP_IPV6: begin
                phase = PH_SKIP;
                byte_count = SKIP_IPV6;
              end
              ATYP_DOMAIN: begin
                phase = PH_DLEN;
                byte_count = '0;
              end
              default: failed = 1'b1;
            endcase
          end
        end
        PH_DLEN: begin
          if (it.command != CMD_RECV) begin
            failed = 1'b1;
          end else begin
            phase = PH_SKIP;
            byte_count = {1'b0, it.data_byte} + PORT_LEN;
          end
        end
        PH_SKIP: begin
          if (it.command != CMD_RECV) begin
            failed = 1'b1;
          end else if (byte_count > 9'd1) begin
            byte_count = byte_count - 9'd1;
          end else begin
            emit(KIND_OK, 8'h00);
            phase = PH_IDLE;
            byte_count = '0;
          end
        end
        default: failed = 1'b1;
      endcase

      // Any failure replaces the results with a single verdict and goes idle.
      if (failed) begin
        step_beats.delete();
        emit(KIND_FAIL, 8'h00);
        phase = PH_IDLE;
        byte_count = '0;
      end
      if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) awaited.push_back(step_beats[i]);
    endfunction

    // Compare one accepted result against the oldest prediction.
    function void check_result(logic [1:0] kind, logic [7:0] tx_byte, logic last);
      out_beat_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind=%0d byte=%02h last=%0b",
                   $time, kind, tx_byte, last);
      end else begin
        want = awaited.pop_front();
        if (kind != want.kind || tx_byte != want.tx_byte || last != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] result %0d: expected kind=%0d byte=%02h last=%0b,",
                      " got kind=%0d byte=%02h last=%0b"},
                     $time, results_seen, want.kind, want.tx_byte, want.last,
                     kind, tx_byte, last);
        end
      end
    endfunction

    // Predictions still waiting when the run ends count as failures.
    function void close_out();
      if (awaited.size() > 0) begin
        $display("%0d predicted results never arrived", awaited.size());
        mismatches += awaited.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_START;
  logic [7:0]  in_data_byte = 8'h00;
  logic [15:0] in_dest_port = 16'h0000;
  logic [7:0]  in_name_length = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  handshake_checker board;
  item_t            plan[$];
  int               items_sent = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_request = 0;
  int               hold_left = 0;

  socks5_client_handshake_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .in_dest_port   (in_dest_port),
    .in_name_length (in_name_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_tx_byte    (out_tx_byte),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted result, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_kind, out_tx_byte, out_last);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [7:0] rnd_byte();
    bit [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  // A transaction with random content in the fields its command ignores.
  function automatic item_t make_item(logic [1:0] cmd, logic [7:0] data);
    item_t     it;
    bit [31:0] r;
    r = $urandom;
    it.command = cmd;
    it.data_byte = data;
    it.dest_port = r[15:0];
    it.name_length = r[23:16];
    return it;
  endfunction

  function automatic item_t make_start(logic [15:0] port, logic [7:0] len);
    item_t it;
    it = make_item(CMD_START, rnd_byte());
    it.dest_port = port;
    it.name_length = len;
    return it;
  endfunction

  // Offer one transaction, with a random gap first, and hold it until taken.
  task automatic offer(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.command;
    in_data_byte <= it.data_byte;
    in_dest_port <= it.dest_port;
    in_name_length <= it.name_length;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic drive(input logic [1:0] cmd, input logic [7:0] data,
                       input logic [15:0] port, input logic [7:0] len);
    item_t it;
    it.command = cmd;
    it.data_byte = data;
    it.dest_port = port;
    it.name_length = len;
    offer(it);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // Build one well-formed handshake with random content, optionally damaged
  // at one point and cut short after it.
  function automatic void plan_session(input bit long_name, input bit allow_damage);
    bit [31:0]  r;
    logic [7:0] nlen;
    logic [7:0] atyp;
    logic [7:0] dlen;
    int         skip;
    int         pick;
    int         cut;
    plan.delete();
    if (long_name) r = $urandom_range(32, 48);
    else if ($urandom_range(15) == 0) r = $urandom_range(16, 48);
    else r = $urandom_range(1, 6);
    nlen = r[7:0];
    r = $urandom;
    plan.push_back(make_start(r[15:0], nlen));
    plan.push_back(make_item(CMD_RECV, PROTO_VER));
    plan.push_back(make_item(CMD_RECV, AUTH_NONE));
    for (int i = 0; i < int'(nlen); i++) plan.push_back(make_item(CMD_NAME, rnd_byte()));
    plan.push_back(make_item(CMD_RECV, PROTO_VER));
    plan.push_back(make_item(CMD_RECV, STATUS_OK));
    plan.push_back(make_item(CMD_RECV, rnd_byte()));

    // Address type: mostly IPv4, some IPv6 and domain, now and then an unknown one.
    pick = $urandom_range(9);
    skip = 0;
    if (pick < 4) begin
      plan.push_back(make_item(CMD_RECV, ATYP_IPV4));
      skip = int'(SKIP_IPV4);
    end else if (pick < 6) begin
      plan.push_back(make_item(CMD_RECV, ATYP_IPV6));
      skip = int'(SKIP_IPV6);
    end else if (pick < 9) begin
      plan.push_back(make_item(CMD_RECV, ATYP_DOMAIN));
      if ($urandom_range(3) == 0) r = 0;
      else r = $urandom_range(1, 12);
      dlen = r[7:0];
      plan.push_back(make_item(CMD_RECV, dlen));
      skip = int'(dlen) + int'(PORT_LEN);
    end else begin
      atyp = rnd_byte();
      while (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 || atyp == ATYP_DOMAIN)
        atyp = rnd_byte();
      plan.push_back(make_item(CMD_RECV, atyp));
    end
    for (int i = 0; i < skip; i++) plan.push_back(make_item(CMD_RECV, rnd_byte()));

    // Damage one transaction: a wrong command or a wrong byte.
    if (allow_damage && $urandom_range(5) == 0) begin
      cut = $urandom_range(1, plan.size() - 1);
      r = $urandom;
      if (r[8]) plan[cut].command = r[1:0];
      else plan[cut].data_byte = r[7:0];
      while (plan.size() > cut + 1) void'(plan.pop_back());
    end
  endfunction

  // One handshake, after forcing the block back to idle if it is mid-way.
  task automatic run_session(input bit long_name, input bit allow_damage);
    if (board.phase != PH_IDLE) offer(make_item(CMD_BAD, rnd_byte()));
    plan_session(long_name, allow_damage);
    foreach (plan[i]) offer(plan[i]);
  endtask

  // Random handshakes mixed with stray transactions that fail straight away.
  task automatic run_random(input int target);
    int    goal;
    item_t it;
    goal = items_sent + target;
    while (items_sent < goal) begin
      if ($urandom_range(5) == 0) begin
        if ($urandom_range(3) == 0) begin
          it = make_start(16'h0000, 8'h00);
          it.dest_port = {rnd_byte(), rnd_byte()};
        end else begin
          it = make_item(2'($urandom_range(1, 3)), rnd_byte());
        end
        if (board.phase == PH_IDLE) offer(it);
      end
      run_session(1'b0, 1'b1);
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: sender rarely idles, receiver mostly stalls.
    send_idle_pct = 11;
    recv_idle_pct = 71;
    // Zero name length and commands that idle does not accept.
    drive(CMD_START, 8'hff, 16'hffff, 8'h00);
    drive(CMD_BAD, 8'hff, 16'hffff, 8'hff);
    drive(CMD_NAME, 8'h00, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'h05, 16'h0000, 8'h01);
    // Longest name, then a second start while the handshake is running.
    drive(CMD_START, 8'hff, 16'hffff, 8'hff);
    drive(CMD_START, 8'h00, 16'h0000, 8'h01);
    // Bad second byte in the greeting reply.
    drive(CMD_START, 8'h00, 16'h0000, 8'h01);
    drive(CMD_RECV, PROTO_VER, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'h01, 16'h0000, 8'h00);
    // Complete handshake whose bound address is an empty domain name.
    drive(CMD_START, 8'h00, 16'h1234, 8'h01);
    drive(CMD_RECV, PROTO_VER, 16'hffff, 8'hff);
    drive(CMD_RECV, AUTH_NONE, 16'hffff, 8'hff);
    drive(CMD_NAME, 8'hff, 16'h0000, 8'h00);
    drive(CMD_RECV, PROTO_VER, 16'h0000, 8'h00);
    drive(CMD_RECV, STATUS_OK, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'hff, 16'h0000, 8'h00);
    drive(CMD_RECV, ATYP_DOMAIN, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'h00, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'haa, 16'h0000, 8'h00);
    drive(CMD_RECV, 8'h55, 16'h0000, 8'h00);
    run_random(40);
    wait_drained();

    // Sender mostly idle, receiver rarely stalls.
    send_idle_pct = 71;
    recv_idle_pct = 11;
    run_random(40);
    wait_drained();

    // No idling; a long receiver hold-off fills the block during a long name.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 80;
    run_session(1'b1, 1'b0);
    wait_drained();
    run_random(40);
    wait_drained();

    repeat (10) @(posedge clk);
    board.close_out();
    $display("Covered %0d input transactions and %0d results across three idling regimes,",
             items_sent, board.results_seen);
    $display("including an output hold-off long enough to back up the input channel.");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(5_000_000);
    $display("Timed out with %0d results still awaited", board.awaited.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
